FILE: rtl/core/tbfa_pkg.sv
package tbfa_pkg;

    localparam int SumCount = 12;
    localparam logic [63:0] SumMax = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int QueueDepth = 4;
    localparam int FactorCount = 15;

    typedef enum logic [2:0] {
        FUNC_TRADE  = 3'd0,
        FUNC_CANCEL = 3'd1,
        FUNC_NEW    = 3'd2,
        FUNC_BID_BK = 3'd3,
        FUNC_OFF_BK = 3'd4,
        FUNC_CLOSE  = 3'd5
    } func_t;

    localparam logic [3:0] S_TRADE_VOL    = 4'd0;
    localparam logic [3:0] S_TRADE_AMT    = 4'd1;
    localparam logic [3:0] S_BID_ORD      = 4'd2;
    localparam logic [3:0] S_OFFER_ORD    = 4'd3;
    localparam logic [3:0] S_BID_BOOK     = 4'd4;
    localparam logic [3:0] S_OFFER_BOOK   = 4'd5;
    localparam logic [3:0] S_INIT_BUY     = 4'd6;
    localparam logic [3:0] S_INIT_SELL    = 4'd7;
    localparam logic [3:0] S_CANCEL_BID   = 4'd8;
    localparam logic [3:0] S_CANCEL_OFFER = 4'd9;
    localparam logic [3:0] S_EP_BUY       = 4'd10;
    localparam logic [3:0] S_EP_SELL      = 4'd11;

    // Classified word passed from the front part to the back part.
    typedef struct packed {
        logic        close;
        logic        trade;
        logic [23:0] price;
        logic [31:0] qty;
        logic [SumCount-1:0] add_mask;
        logic        buy_seen;
        logic        sell_seen;
    } op_t;

endpackage

FILE: rtl/core/trade_bar_factor_aggregator.sv
// Bar factor aggregator for one symbol.
// Input words are pushed with push while full is low; one word can be taken
// each cycle. A front stage registers the word, forms the premium products
// and classifies it into a short queue; the back part updates the bar state.
// A trade's amount product is added in the cycle after the trade is taken,
// and the back part takes no new word until that add is done.
// A close word causes fifteen result words, factor indexes 0 to 14, with
// last high on the fifteenth. The return rate comes from a restoring divider
// that is skipped when no trade price is held; after it, the results follow
// one result per cycle while pop is held.
// Results are read as a queue: a result is on the ports while empty is low
// and leaves on pop. If pop stays low, the back part waits, the queue fills
// and full rises. Reset clears the bar state and sets the premium to 3 percent.
// The configuration channel is ready whenever the block is idle.
module trade_bar_factor_aggregator
    import tbfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  func,
    input  logic [23:0] price,
    input  logic [31:0] quantity,
    input  logic [31:0] bid_seq,
    input  logic [31:0] offer_seq,
    input  logic [23:0] bid_price,
    input  logic [23:0] offer_price,
    input  logic [1:0]  side,
    input  logic        valid_req,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  factor_index,
    output logic [63:0] factor_value,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  premium_percent
);

    logic [6:0] prem_reg;
    logic       f_busy;
    logic       b_busy;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    op_t        q_in;
    op_t        q_out;
    logic       stall;

    assign stall = f_busy && q_full;
    assign full = stall;
    assign cfg_ready = !f_busy && q_empty && !b_busy && empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prem_reg <= 7'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            prem_reg <= premium_percent;
        end
    end

    tbfa_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(push && !stall), .func(func),
        .price(price), .quantity(quantity), .bid_seq(bid_seq),
        .offer_seq(offer_seq), .bid_price(bid_price), .offer_price(offer_price),
        .side(side), .valid_req(valid_req), .premium(prem_reg),
        .q_full(q_full), .q_push(q_push), .q_word(q_in), .busy(f_busy)
    );

    tbfa_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_word(q_in),
        .full(q_full), .pop(q_pop), .pop_word(q_out), .empty(q_empty)
    );

    tbfa_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_word(q_out),
        .q_pop(q_pop), .factor_index(factor_index), .factor_value(factor_value),
        .last(last), .empty(empty), .pop(pop), .busy(b_busy)
    );

endmodule

FILE: rtl/core/tbfa_front.sv
module tbfa_front
    import tbfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [2:0]  func,
    input  logic [23:0] price,
    input  logic [31:0] quantity,
    input  logic [31:0] bid_seq,
    input  logic [31:0] offer_seq,
    input  logic [23:0] bid_price,
    input  logic [23:0] offer_price,
    input  logic [1:0]  side,
    input  logic        valid_req,
    input  logic [6:0]  premium,
    input  logic        q_full,
    output logic        q_push,
    output op_t         q_word,
    output logic        busy
);

    logic        stg_valid_reg;
    logic [2:0]  stg_func_reg;
    logic [23:0] stg_price_reg;
    logic [31:0] stg_qty_reg;
    logic [31:0] stg_bseq_reg;
    logic [31:0] stg_oseq_reg;
    logic [1:0]  stg_side_reg;
    logic        stg_ok_reg;
    logic [33:0] stg_bid100_reg;
    logic [33:0] stg_off100_reg;
    logic [31:0] stg_up_reg;
    logic [31:0] stg_dn_reg;
    logic        stg_dn_neg_reg;
    logic        take;
    logic        keep;
    logic [7:0]  up_pct;
    logic [7:0]  dn_pct;
    logic        ep_buy;
    logic        ep_sell;

    assign keep = stg_valid_reg && q_full;
    assign take = in_valid && !keep;
    assign busy = stg_valid_reg;
    assign up_pct = 8'd100 + {1'b0, premium};
    assign dn_pct = 8'd100 - {1'b0, premium};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (!keep)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stg_func_reg   <= func;
            stg_price_reg  <= price;
            stg_qty_reg    <= quantity;
            stg_bseq_reg   <= bid_seq;
            stg_oseq_reg   <= offer_seq;
            stg_side_reg   <= side;
            stg_ok_reg     <= valid_req;
            stg_bid100_reg <= {10'd0, bid_price} * 34'd100;
            stg_off100_reg <= {10'd0, offer_price} * 34'd100;
            stg_up_reg     <= {8'd0, price} * {24'd0, up_pct};
            stg_dn_reg     <= {8'd0, price} * {24'd0, dn_pct};
            stg_dn_neg_reg <= (premium > 7'd100);
        end
    end

    // With a threshold above 100 percent the sell bound is negative, or zero at a zero price.
    assign ep_buy  = {2'b0, stg_bid100_reg} >= {4'b0, stg_up_reg};
    assign ep_sell = stg_dn_neg_reg ? (stg_off100_reg == 34'd0 && stg_price_reg == 24'd0)
                     : ({2'b0, stg_off100_reg} <= {4'b0, stg_dn_reg});

    always_comb
    begin
        q_word = '0;
        q_word.price = stg_price_reg;
        q_word.qty = stg_qty_reg;
        q_word.buy_seen = stg_bseq_reg < stg_oseq_reg;
        q_word.sell_seen = stg_oseq_reg < stg_bseq_reg;
        q_push = 1'b0;
        if (stg_valid_reg && !q_full)
        begin
            if (stg_func_reg == FUNC_CLOSE)
            begin
                q_word.close = 1'b1;
                q_push = 1'b1;
            end
            else if (stg_ok_reg)
            begin
                case (stg_func_reg)
                    FUNC_TRADE:
                    begin
                        q_push = 1'b1;
                        q_word.trade = 1'b1;
                        q_word.add_mask[S_TRADE_VOL] = 1'b1;
                        q_word.add_mask[S_TRADE_AMT] = 1'b1;
                        q_word.add_mask[S_INIT_BUY] = stg_bseq_reg > stg_oseq_reg;
                        q_word.add_mask[S_INIT_SELL] = stg_bseq_reg < stg_oseq_reg;
                        q_word.add_mask[S_EP_BUY] = ep_buy;
                        q_word.add_mask[S_EP_SELL] = ep_sell;
                    end
                    FUNC_CANCEL:
                    begin
                        q_push = 1'b1;
                        q_word.add_mask[S_CANCEL_BID] = stg_bseq_reg != 32'd0;
                        q_word.add_mask[S_CANCEL_OFFER] = stg_oseq_reg != 32'd0;
                    end
                    FUNC_NEW:
                    begin
                        q_push = 1'b1;
                        q_word.add_mask[S_BID_ORD] = stg_side_reg == 2'd0;
                        q_word.add_mask[S_OFFER_ORD] = stg_side_reg == 2'd1;
                    end
                    FUNC_BID_BK:
                    begin
                        q_push = 1'b1;
                        q_word.add_mask[S_BID_BOOK] = 1'b1;
                    end
                    FUNC_OFF_BK:
                    begin
                        q_push = 1'b1;
                        q_word.add_mask[S_OFFER_BOOK] = 1'b1;
                    end
                    default:
                    begin
                        q_push = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/core/tbfa_queue.sv
module tbfa_queue
    import tbfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_word,
    output logic full,
    input  logic pop,
    output op_t  pop_word,
    output logic empty
);

    localparam int AddrW = $clog2(QueueDepth);

    op_t              mem_reg [QueueDepth];
    logic [AddrW-1:0] wr_reg;
    logic [AddrW-1:0] rd_reg;
    logic [AddrW:0]   cnt_reg;

    assign full = cnt_reg == (AddrW+1)'(QueueDepth);
    assign empty = cnt_reg == '0;
    assign pop_word = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/tbfa_back.sv
module tbfa_back
    import tbfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  op_t         q_word,
    output logic        q_pop,
    output logic [3:0]  factor_index,
    output logic [63:0] factor_value,
    output logic        last,
    output logic        empty,
    input  logic        pop,
    output logic        busy
);

    typedef enum logic [2:0] {
        ST_RUN,
        ST_AMT,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t       state_reg;
    logic [23:0]  first_reg;
    logic [23:0]  last_price_reg;
    logic         held_reg;
    logic         buy_reg;
    logic         sell_reg;
    logic [63:0]  sums_reg [SumCount];
    logic [55:0]  amt_reg;
    logic         amt_pend_reg;
    logic [48:0]  num_reg;
    logic [48:0]  quo_reg;
    logic [24:0]  rem_reg;
    logic         neg_reg;
    logic [5:0]   step_reg;
    logic [3:0]   idx_reg;
    logic         out_valid_reg;
    logic [63:0]  val_reg;
    logic [63:0]  rate;
    logic [23:0]  first_new;
    logic [24:0]  diff_mag;
    logic [25:0]  rem_try;
    logic [63:0]  f_val;
    logic         out_free;

    assign out_free = !out_valid_reg || pop;
    assign empty = !out_valid_reg;
    assign factor_value = val_reg;
    assign last = out_valid_reg && idx_reg == 4'(FactorCount - 1) ? 1'b1 : 1'b0;
    assign busy = state_reg != ST_RUN || amt_pend_reg;
    assign q_pop = state_reg == ST_RUN && !q_empty && !amt_pend_reg
                   && (!q_word.close || !out_valid_reg);
    assign first_new = (first_reg == 24'd0) ? q_word.price : first_reg;
    assign diff_mag = (last_price_reg >= first_reg) ?
                      {1'b0, last_price_reg - first_reg} : {1'b0, first_reg - last_price_reg};
    assign rem_try = {rem_reg, num_reg[48]} - {2'b0, first_reg};
    assign rate = neg_reg ? -{15'd0, quo_reg} : {15'd0, quo_reg};

    function automatic logic [63:0] f_val_next(input logic [3:0] i);
        logic [3:0] n;
        logic [63:0] r;
        begin
            n = i + 4'd1;
            case (n)
                4'd1: r = {63'd0, held_reg && !buy_reg};
                4'd2: r = {63'd0, held_reg && !sell_reg};
                default: r = sums_reg[n - 4'd3];
            endcase
            return r;
        end
    endfunction

    always_comb
    begin
        case (idx_reg)
            4'd0: f_val = (first_reg == 24'd0) ? 64'd0 : rate;
            4'd1: f_val = {63'd0, held_reg && !buy_reg};
            4'd2: f_val = {63'd0, held_reg && !sell_reg};
            default: f_val = sums_reg[idx_reg - 4'd3];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            first_reg <= '0;
            last_price_reg <= '0;
            held_reg <= 1'b1;
            buy_reg <= 1'b0;
            sell_reg <= 1'b0;
            for (int i = 0; i < SumCount; i++)
            begin
                sums_reg[i] <= '0;
            end
            amt_pend_reg <= 1'b0;
            amt_reg <= '0;
            num_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
            neg_reg <= 1'b0;
            step_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            val_reg <= '0;
        end
        else
        begin
            if (amt_pend_reg)
            begin
                amt_pend_reg <= 1'b0;
                if ({8'd0, amt_reg} > SumMax - sums_reg[S_TRADE_AMT])
                begin
                    sums_reg[S_TRADE_AMT] <= SumMax;
                end
                else
                begin
                    sums_reg[S_TRADE_AMT] <= sums_reg[S_TRADE_AMT] + {8'd0, amt_reg};
                end
            end
            case (state_reg)
                ST_RUN:
                begin
                    if (q_pop)
                    begin
                        if (q_word.close)
                        begin
                            neg_reg <= last_price_reg < first_reg;
                            num_reg <= {diff_mag, 24'd0};
                            rem_reg <= '0;
                            quo_reg <= '0;
                            step_reg <= '0;
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            if (q_word.trade)
                            begin
                                first_reg <= first_new;
                                last_price_reg <= q_word.price;
                                held_reg <= (first_new == 24'd0) || (q_word.price == first_new);
                                buy_reg <= q_word.buy_seen;
                                sell_reg <= q_word.sell_seen;
                                amt_reg <= {32'd0, q_word.price} * {24'd0, q_word.qty};
                                amt_pend_reg <= 1'b1;
                            end
                            for (int i = 0; i < SumCount; i++)
                            begin
                                if (q_word.add_mask[i] && 4'(i) != S_TRADE_AMT)
                                begin
                                    if ({32'd0, q_word.qty} > SumMax - sums_reg[i])
                                    begin
                                        sums_reg[i] <= SumMax;
                                    end
                                    else
                                    begin
                                        sums_reg[i] <= sums_reg[i] + {32'd0, q_word.qty};
                                    end
                                end
                            end
                        end
                    end
                end
                ST_DIV:
                begin
                    if (first_reg == 24'd0 || step_reg == 6'd49)
                    begin
                        idx_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                        num_reg <= {num_reg[47:0], 1'b0};
                        if (!rem_try[25])
                        begin
                            rem_reg <= rem_try[24:0];
                            quo_reg <= {quo_reg[47:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[23:0], num_reg[48]};
                            quo_reg <= {quo_reg[47:0], 1'b0};
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        if (out_valid_reg && idx_reg == 4'(FactorCount - 1))
                        begin
                            out_valid_reg <= 1'b0;
                            first_reg <= '0;
                            last_price_reg <= '0;
                            held_reg <= 1'b1;
                            buy_reg <= 1'b0;
                            sell_reg <= 1'b0;
                            for (int i = 0; i < SumCount; i++)
                            begin
                                sums_reg[i] <= '0;
                            end
                            state_reg <= ST_RUN;
                        end
                        else
                        begin
                            if (out_valid_reg)
                            begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                            out_valid_reg <= 1'b1;
                            val_reg <= out_valid_reg ? f_val_next(idx_reg) : f_val;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    assign factor_index = idx_reg;

endmodule

FILE: rtl/core/tbfa_checker.sv
module tbfa_checker
    import tbfa_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [3:0] factor_index,
    input logic       last,
    input logic       cfg_ready,
    input logic       full
);

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last == (factor_index == 4'(FactorCount - 1))))
        else $error("last does not match the final factor");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=> (!empty |-> factor_index == $past(factor_index) + 4'd1))
        else $error("factor index skipped");

    a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(factor_index)))
        else $error("result word dropped while stalled");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (empty && !full))
        else $error("configuration ready while busy");

endmodule

bind trade_bar_factor_aggregator tbfa_checker u_tbfa_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .factor_index(factor_index), .last(last), .cfg_ready(cfg_ready), .full(full)
);

FILE: bench/trade_bar_factor_aggregator_tb.sv
`timescale 1ns / 100ps

module trade_bar_factor_aggregator_tb;
    import tbfa_pkg::*;

    localparam logic [63:0] BarSumMax = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int SumTradeVol = 0;
    localparam int SumTradeAmt = 1;
    localparam int SumBidOrd = 2;
    localparam int SumOfferOrd = 3;
    localparam int SumBidBook = 4;
    localparam int SumOfferBook = 5;
    localparam int SumInitBuy = 6;
    localparam int SumInitSell = 7;
    localparam int SumCancelBid = 8;
    localparam int SumCancelOffer = 9;
    localparam int SumEpBuy = 10;
    localparam int SumEpSell = 11;
    localparam logic [1:0] SideBid = 2'd0;
    localparam logic [1:0] SideOffer = 2'd1;
    localparam logic [1:0] SideOther = 2'd2;

    typedef struct packed {
        logic [3:0]  index;
        logic [63:0] value;
        logic        last;
    } factor_word_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [23:0] price;
        logic [31:0] qty;
        logic [31:0] bseq;
        logic [31:0] oseq;
        logic [23:0] bprice;
        logic [23:0] oprice;
        logic [1:0]  side;
        logic        valid;
    } event_word_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  func;
    logic [23:0] price;
    logic [31:0] quantity;
    logic [31:0] bid_seq;
    logic [31:0] offer_seq;
    logic [23:0] bid_price;
    logic [23:0] offer_price;
    logic [1:0]  side;
    logic        valid_req;
    logic        empty;
    logic        pop;
    logic [3:0]  factor_index;
    logic [63:0] factor_value;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  premium_percent;

    logic [6:0]  bar_premium;
    logic [23:0] bar_first_price;
    logic [23:0] bar_last_price;
    logic        bar_price_held;
    logic        bar_buy_seen;
    logic        bar_sell_seen;
    logic [63:0] bar_sums [12];

    factor_word_t expected_factors [$];
    int unsigned  mismatches;
    int unsigned  pop_wait;

    trade_bar_factor_aggregator DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .price(price), .quantity(quantity), .bid_seq(bid_seq),
        .offer_seq(offer_seq), .bid_price(bid_price), .offer_price(offer_price),
        .side(side), .valid_req(valid_req), .empty(empty), .pop(pop),
        .factor_index(factor_index), .factor_value(factor_value), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .premium_percent(premium_percent)
    );

    always #10 clk = ~clk;

    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic void clear_bar_state();
        bar_first_price = '0;
        bar_last_price = '0;
        bar_price_held = 1'b1;
        bar_buy_seen = 1'b0;
        bar_sell_seen = 1'b0;
        for (int k = 0; k < 12; k++)
            bar_sums[k] = '0;
    endfunction

    function automatic void add_saturating(int which, logic [63:0] amount);
        if (amount > BarSumMax - bar_sums[which])
            bar_sums[which] = BarSumMax;
        else
            bar_sums[which] = bar_sums[which] + amount;
    endfunction

    function automatic void accumulate_event(event_word_t ev);
        logic signed [63:0] pct;
        logic signed [63:0] diff;
        logic signed [63:0] rate;
        factor_word_t fw;
        pct = $signed({57'd0, bar_premium});
        if (ev.func == FUNC_CLOSE)
        begin
            rate = '0;
            if (bar_first_price != 0)
            begin
                diff = $signed({40'd0, bar_last_price}) - $signed({40'd0, bar_first_price});
                rate = (diff * 64'sd16777216) / $signed({40'd0, bar_first_price});
            end
            for (int k = 0; k < 15; k++)
            begin
                fw.index = k[3:0];
                fw.last = (k == 14);
                if (k == 0)
                    fw.value = rate;
                else if (k == 1)
                    fw.value = {63'd0, bar_price_held && !bar_buy_seen};
                else if (k == 2)
                    fw.value = {63'd0, bar_price_held && !bar_sell_seen};
                else
                    fw.value = bar_sums[k - 3];
                expected_factors = {expected_factors, fw};
            end
            clear_bar_state();
        end
        else if (ev.valid)
        begin
            case (ev.func)
                FUNC_TRADE:
                begin
                    if (bar_first_price == 0)
                        bar_first_price = ev.price;
                    bar_last_price = ev.price;
                    bar_price_held = (bar_first_price == 0) || (ev.price == bar_first_price);
                    bar_buy_seen = ev.bseq < ev.oseq;
                    bar_sell_seen = ev.oseq < ev.bseq;
                    add_saturating(SumTradeVol, {32'd0, ev.qty});
                    add_saturating(SumTradeAmt, {40'd0, ev.price} * {32'd0, ev.qty});
                    if (ev.bseq > ev.oseq)
                        add_saturating(SumInitBuy, {32'd0, ev.qty});
                    if (ev.bseq < ev.oseq)
                        add_saturating(SumInitSell, {32'd0, ev.qty});
                    if ($signed({40'd0, ev.bprice}) * 100 >=
                        $signed({40'd0, ev.price}) * (64'sd100 + pct))
                        add_saturating(SumEpBuy, {32'd0, ev.qty});
                    if ($signed({40'd0, ev.oprice}) * 100 <=
                        $signed({40'd0, ev.price}) * (64'sd100 - pct))
                        add_saturating(SumEpSell, {32'd0, ev.qty});
                end
                FUNC_CANCEL:
                begin
                    if (ev.bseq > 0)
                        add_saturating(SumCancelBid, {32'd0, ev.qty});
                    if (ev.oseq > 0)
                        add_saturating(SumCancelOffer, {32'd0, ev.qty});
                end
                FUNC_NEW:
                begin
                    if (ev.side == SideBid)
                        add_saturating(SumBidOrd, {32'd0, ev.qty});
                    else if (ev.side == SideOffer)
                        add_saturating(SumOfferOrd, {32'd0, ev.qty});
                end
                FUNC_BID_BK: add_saturating(SumBidBook, {32'd0, ev.qty});
                FUNC_OFF_BK: add_saturating(SumOfferBook, {32'd0, ev.qty});
                default: ;
            endcase
        end
    endfunction

    task automatic send_event(event_word_t ev);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        {func, price, quantity, bid_seq, offer_seq, bid_price, offer_price, side,
            valid_req} <= ev;
        @(posedge clk);
        while (full)
            @(posedge clk);
        accumulate_event(ev);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_factors.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_premium(logic [6:0] pct);
        wait_drained();
        cfg_valid <= 1'b1;
        premium_percent <= pct;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        bar_premium = pct;
    endtask

    function automatic event_word_t random_event(bit well_formed);
        event_word_t ev;
        logic [255:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        ev = rnd[$bits(event_word_t)-1:0];
        if (well_formed)
        begin
            ev.func = 3'($urandom_range(0, 4));
            ev.valid = ($urandom_range(0, 9) != 0);
            ev.price = $urandom_range(0, 15) == 0 ? 24'd0 : 24'($urandom_range(900, 1100));
            ev.bprice = ev.price + 24'($urandom_range(0, 80)) - 24'd40;
            ev.oprice = ev.price + 24'($urandom_range(0, 80)) - 24'd40;
            if ($urandom_range(0, 1))
                ev.price = 24'($urandom_range(1000, 1002));
            if ($urandom_range(0, 2) == 0)
                ev.bseq = 0;
            if ($urandom_range(0, 2) == 0)
                ev.oseq = 0;
            if ($urandom_range(0, 3) != 0)
                ev.qty = $urandom_range(0, 100000);
        end
        else if (ev.func == FUNC_CLOSE)
            ev.func = FUNC_TRADE;
        return ev;
    endfunction

    function automatic event_word_t make_event(logic [2:0] f, logic [23:0] p, logic [31:0] q,
        logic [31:0] bs, logic [31:0] os, logic [23:0] bp, logic [23:0] op, logic [1:0] sd,
        logic v);
        event_word_t ev;
        ev = {f, p, q, bs, os, bp, op, sd, v};
        return ev;
    endfunction

    task automatic close_bar();
        send_event(make_event(FUNC_CLOSE, 24'($urandom), $urandom, $urandom, $urandom,
            24'($urandom), 24'($urandom), 2'($urandom), 1'($urandom)));
    endtask

    task automatic test_empty_bar();
        close_bar();
    endtask

    task automatic test_every_event();
        send_event(make_event(FUNC_TRADE, 24'd0, 32'd10, 32'd1, 32'd2, 24'd0, 24'd0,
            SideBid, 1'b1));
        send_event(make_event(FUNC_TRADE, 24'd1000, 32'd100, 32'd5, 32'd3, 24'd1030,
            24'd970, SideBid, 1'b1));
        send_event(make_event(FUNC_TRADE, 24'd1000, 32'd7, 32'd3, 32'd3, 24'd1029,
            24'd971, SideBid, 1'b1));
        send_event(make_event(FUNC_CANCEL, 24'd0, 32'd11, 32'd4, 32'd0, 24'd0, 24'd0,
            SideBid, 1'b1));
        send_event(make_event(FUNC_CANCEL, 24'd0, 32'd12, 32'd0, 32'd4, 24'd0, 24'd0,
            SideBid, 1'b1));
        send_event(make_event(FUNC_NEW, 24'd0, 32'd13, 32'd0, 32'd0, 24'd0, 24'd0,
            SideBid, 1'b1));
        send_event(make_event(FUNC_NEW, 24'd0, 32'd14, 32'd0, 32'd0, 24'd0, 24'd0,
            SideOffer, 1'b1));
        send_event(make_event(FUNC_NEW, 24'd0, 32'd15, 32'd0, 32'd0, 24'd0, 24'd0,
            SideOther, 1'b1));
        send_event(make_event(FUNC_NEW, 24'd0, 32'd15, 32'd0, 32'd0, 24'd0, 24'd0,
            2'd3, 1'b1));
        send_event(make_event(FUNC_BID_BK, 24'd0, 32'd16, 32'd0, 32'd0, 24'd0, 24'd0,
            SideBid, 1'b1));
        send_event(make_event(FUNC_OFF_BK, 24'd0, 32'd17, 32'd0, 32'd0, 24'd0, 24'd0,
            SideBid, 1'b1));
        send_event(make_event(FUNC_BID_BK, 24'd0, 32'd99, 32'd0, 32'd0, 24'd0, 24'd0,
            SideBid, 1'b0));
        send_event(make_event(3'd6, 24'd5, 32'd99, 32'd1, 32'd0, 24'd0, 24'd0, SideBid, 1'b1));
        send_event(make_event(3'd7, 24'd5, 32'd99, 32'd1, 32'd0, 24'd0, 24'd0, SideBid, 1'b1));
        send_event(make_event(FUNC_TRADE, 24'd900, 32'd1, 32'd0, 32'd9, 24'd0, 24'hFFFFFF,
            SideBid, 1'b1));
        close_bar();
    endtask

    task automatic test_extremes();
        send_event(make_event(FUNC_TRADE, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0,
            24'hFFFFFF, 24'd0, 2'd3, 1'b1));
        send_event(make_event(FUNC_TRADE, 24'd1, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF,
            24'hFFFFFF, 24'd0, 2'd3, 1'b1));
        close_bar();
        send_event(make_event(FUNC_TRADE, 24'd1, 32'd1, 32'd0, 32'd0, 24'd0, 24'hFFFFFF,
            SideBid, 1'b1));
        send_event(make_event(FUNC_TRADE, 24'hFFFFFF, 32'd1, 32'd0, 32'd0, 24'd0, 24'd0,
            SideBid, 1'b1));
        close_bar();
    endtask

    task automatic test_saturation();
        for (int k = 0; k < 6; k++)
            send_event(make_event(FUNC_TRADE, 24'hFFFFFF, 32'hFFFFFFFF, 32'd2, 32'd1,
                24'hFFFFFF, 24'd0, SideBid, 1'b1));
        close_bar();
    endtask

    task automatic test_random_bars(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 12) == 0)
                close_bar();
            else
                send_event(random_event($urandom_range(0, 9) != 0));
            n++;
        end
        close_bar();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        cfg_valid = 1'b0;
        premium_percent = 7'd3;
        {func, price, quantity, bid_seq, offer_seq, bid_price, offer_price, side,
            valid_req} = '0;
        mismatches = 0;
        bar_premium = 7'd3;
        clear_bar_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_bar();
        test_every_event();
        test_extremes();
        test_saturation();
        write_premium(7'd0);
        test_random_bars(120);
        write_premium(7'd100);
        test_random_bars(80);
        write_premium(7'd127);
        test_every_event();
        test_random_bars(60);
        write_premium(7'($urandom_range(1, 10)));
        test_random_bars(180);
        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin
        factor_word_t want;
        if (!rst_n)
        begin
            pop_wait = 0;
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_factors.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word index %0d value %0h", $time,
                        factor_index, factor_value);
                end
                else
                begin
                    want = expected_factors.pop_front();
                    if (factor_index !== want.index || factor_value !== want.value ||
                        last !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: expected %0d/%0h/%0b actual %0d/%0h/%0b", $time,
                            want.index, want.value, want.last, factor_index,
                            factor_value, last);
                    end
                end
                pop_wait = $urandom_range(0, 4);
            end
            else if (pop_wait != 0)
                pop_wait--;
            pop <= (pop_wait == 0);
        end
    end

endmodule
